// File: sv/assert_macros.svh
// assertion macros used by sorted_priority_queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spq assertion failed");
`define SPQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spq assertion failed");
`else
`define SPQ_ASSERT(label, clk, rst, prop)
`define SPQ_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: sv/spq_pkg.sv
// types and constants of the sorted priority queue
package spq_pkg;
  localparam int CAPACITY_DEFAULT = 16;
  localparam int VALUE_W = 32;
  localparam int PRIO_W = 16;
  localparam int OCC_W = 5;
  localparam int STATUS_W = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DELETED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } cmd_t;
endpackage

// File: sv/spq_if.sv
// request and response channel interfaces
interface spq_req_if;
  import spq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [VALUE_W-1:0] item_value;
  logic signed [PRIO_W-1:0]  item_priority;
  modport source (output valid, output func, output item_value, output item_priority,
                  input ready);
  modport sink (input valid, input func, input item_value, input item_priority,
                output ready);
endinterface

interface spq_rsp_if;
  import spq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [VALUE_W-1:0] out_value;
  logic signed [PRIO_W-1:0]  out_priority;
  logic [OCC_W-1:0]          occupancy;
  modport source (output valid, output status, output out_value, output out_priority,
                  output occupancy, input ready);
  modport sink (input valid, input status, input out_value, input out_priority,
                input occupancy, output ready);
endinterface

// File: sv/spq_cell.sv
// one slot of the sorted shift chain
module spq_cell (
  input  logic            clk,
  input  logic            rst,
  input  spq_pkg::cmd_t   cmd,
  input  spq_pkg::entry_t left,
  input  logic            left_ahead,
  input  spq_pkg::entry_t right,
  output spq_pkg::entry_t cur,
  output logic            ahead
);
  import spq_pkg::*;

  entry_t cur_next;

  // new entry lands ahead of this slot
  assign ahead = !cur.valid || (cur.prio > cmd.prio);

  always_comb begin
    cur_next = cur;
    if (cmd.ins && ahead) begin
      if (left_ahead) begin
        cur_next = left;
      end else begin
        cur_next.valid = 1'b1;
        cur_next.value = cmd.value;
        cur_next.prio = cmd.prio;
      end
    end else if (cmd.del) begin
      cur_next = right;
    end
  end

  always_ff @(posedge clk) begin
    cur.value <= cur_next.value;
    cur.prio <= cur_next.prio;
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
  end
endmodule

// File: sv/sorted_priority_queue.sv
// sorted priority queue built from a chain of compare-and-shift cells
//
// req channel carries func (insert or delete), item_value and item_priority.
// rsp channel returns one transaction per request: status, out_value,
// out_priority and the occupancy after the request.
// entries leave lowest priority number first; equal priorities leave in
// arrival order. a delete on an empty queue reports underflow, an insert
// into a full queue is dropped and reports overflow.
// every cell compares the incoming priority in parallel and shifts by one
// slot, so a request is absorbed on acceptance and its response is
// registered. throughput is one transaction per cycle unless rsp stalls.
// that rate comes from the compare and shift across all cells at once.
// rst (synchronous) empties the queue and drops any pending response.
// when the receiver stalls, the response holds and req.ready stays low
// until it is taken, so no request is lost.
`include "assert_macros.svh"
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  spq_req_if.sink      req,
  spq_rsp_if.source    rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  entry_t               cells [CAPACITY];
  logic                 ahead [CAPACITY];
  cmd_t                 cmd;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [STATUS_W-1:0]  status_next;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept = req.valid && req.ready;
  assign full = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  assign cmd.ins = accept && (req.func == FUNC_INSERT) && !full;
  assign cmd.del = accept && (req.func == FUNC_DELETE) && !empty;
  assign cmd.value = req.item_value;
  assign cmd.prio = req.item_priority;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left;
    entry_t right;
    logic   left_ahead;
    if (i == 0) begin : g_head
      assign left = '0;
      assign left_ahead = 1'b0;
    end else begin : g_mid
      assign left = cells[i-1];
      assign left_ahead = ahead[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cells[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .left       (left),
      .left_ahead (left_ahead),
      .right      (right),
      .cur        (cells[i]),
      .ahead      (ahead[i])
    );
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.del) begin
      count_next = count - CW'(1);
    end
  end

  always_comb begin
    case (req.func)
      FUNC_INSERT: status_next = full ? STATUS_OVERFLOW : STATUS_INSERTED;
      FUNC_DELETE: status_next = empty ? STATUS_UNDERFLOW : STATUS_DELETED;
      default:     status_next = STATUS_UNDERFLOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status <= status_next;
      rsp.out_value <= cmd.del ? cells[0].value : '0;
      rsp.out_priority <= cmd.del ? cells[0].prio : '0;
      rsp.occupancy <= OCC_W'(count_next);
    end
  end

  `SPQ_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (count == '0) && !rsp.valid)
  `SPQ_ASSERT(a_count_bound, clk, rst, count <= CW'(CAPACITY))
  `SPQ_ASSERT(a_head_valid, clk, rst, cells[0].valid == (count != '0))
  `SPQ_ASSERT(a_insert_grows, clk, rst, cmd.ins |=> count == $past(count) + CW'(1))
  `SPQ_ASSERT(a_underflow_empty, clk, rst, (accept && !cmd.del && req.func) |-> empty)
endmodule
